// ===== rtl/core/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Shared sizes, codes and transaction types of the block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Map geometry.
    localparam int MAP_BLOCKS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = MAP_BLOCKS / WORD_BITS;
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int OFF_W      = $clog2(WORD_BITS);

    // Field widths.
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;

    // Request codes.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_FREE    = 1'b1;
    localparam logic REGION_USER = 1'b0;
    localparam logic REGION_RT   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_USER_LAST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RT_LAST   = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [IDX_W-1:0] USER_LAST_RESET = 10'd1023;
    localparam logic [IDX_W-1:0] RT_LAST_RESET   = 10'd63;

    // One request transaction.
    typedef struct packed {
        logic             cmd;
        logic             region;
        logic [IDX_W-1:0] start_index;
        logic [CNT_W-1:0] block_count;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic             success;
        logic [IDX_W-1:0] first_block;
    } t_rsp;

endpackage

// ===== rtl/core/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator
// Allocates and frees runs of blocks in a 1024-block occupancy map.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken at a rising edge where start is high and
//   busy is low. An allocate scans the map upward from start_index for the
//   first run of block_count free blocks that ends by the region's last
//   block, marks it used and returns its first block. A free clears a run.
//   Exactly one result transaction follows each request: o_rsp_valid is high
//   for one cycle and the receiver cannot stall it.
//   An allocate steps through dispatch, a start check, a scan of one 32-bit
//   map word per cycle through the single map read port (1 to 32 words), a
//   found test, a mark setup, a read-modify-write of one word per cycle over
//   the words the run covers and a result step. A search that finds no run,
//   or a start past the region end, goes to the fail step; a free skips the
//   scan, and a zero-length allocate or free skips the read-modify-write.
//   One request is in flight at a time; busy is high while it is worked on,
//   and the next request can be taken at the edge that ends the strobe.
//   The configuration channel is always ready; it is to be written while idle, which the block does not enforce.
//   Reset clears the map at once through per-word valid bits and loads the
//   region ends with 1023 and 63.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_rsp_valid,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [IDX_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // Microcode definitions.
    // ------------------------------------------------------------------
    localparam int STEP_W = 4;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SCAN_SETUP,
        ACT_SCAN,
        ACT_ALLOC_SETUP,
        ACT_FREE_SETUP,
        ACT_RMW,
        ACT_RESULT_OK,
        ACT_RESULT_FAIL
    } t_act;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_START,
        C_IS_FREE,
        C_START_PAST,
        C_SCAN_AGAIN,
        C_NOT_FOUND,
        C_ZERO_COUNT,
        C_RMW_AGAIN
    } t_cond;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_DISP  = 4'd1;
    localparam logic [STEP_W-1:0] ST_ACHK  = 4'd2;
    localparam logic [STEP_W-1:0] ST_ASCAN = 4'd3;
    localparam logic [STEP_W-1:0] ST_ATEST = 4'd4;
    localparam logic [STEP_W-1:0] ST_AMARK = 4'd5;
    localparam logic [STEP_W-1:0] ST_RMW   = 4'd6;
    localparam logic [STEP_W-1:0] ST_OK    = 4'd7;
    localparam logic [STEP_W-1:0] ST_FSET  = 4'd8;
    localparam logic [STEP_W-1:0] ST_FJMP  = 4'd9;
    localparam logic [STEP_W-1:0] ST_FAIL  = 4'd10;

    // Control store: a conditional jump goes to target, else to the next step.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            ST_IDLE:  w = '{ACT_NONE,        C_NO_START,   ST_IDLE};
            ST_DISP:  w = '{ACT_NONE,        C_IS_FREE,    ST_FSET};
            ST_ACHK:  w = '{ACT_SCAN_SETUP,  C_START_PAST, ST_FAIL};
            ST_ASCAN: w = '{ACT_SCAN,        C_SCAN_AGAIN, ST_ASCAN};
            ST_ATEST: w = '{ACT_NONE,        C_NOT_FOUND,  ST_FAIL};
            ST_AMARK: w = '{ACT_ALLOC_SETUP, C_ZERO_COUNT, ST_OK};
            ST_RMW:   w = '{ACT_RMW,         C_RMW_AGAIN,  ST_RMW};
            ST_OK:    w = '{ACT_RESULT_OK,   C_ALWAYS,     ST_IDLE};
            ST_FSET:  w = '{ACT_FREE_SETUP,  C_ZERO_COUNT, ST_OK};
            ST_FJMP:  w = '{ACT_NONE,        C_ALWAYS,     ST_RMW};
            ST_FAIL:  w = '{ACT_RESULT_FAIL, C_ALWAYS,     ST_IDLE};
            default:  w = '{ACT_NONE,        C_ALWAYS,     ST_IDLE};
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]    r_step, n_step;
    t_req                 r_req;
    logic [IDX_W-1:0]     r_user_last, r_rt_last;
    logic [IDX_W-1:0]     r_last;
    logic [CNT_W-1:0]     r_need;
    logic [CNT_W-1:0]     r_len;
    logic                 r_first_word;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_found;
    logic [IDX_W-1:0]     r_first;
    logic [IDX_W-1:0]     r_lo, r_hi;
    logic                 r_set;
    logic                 r_rsp_valid;
    t_rsp                 r_rsp;

    // Map memory, its valid bits and its registered read port.
    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_row_valid;
    logic [WORD_BITS-1:0] r_rd_word;
    logic                 r_rd_ok;

    t_uword               uw;
    logic                 cond_true;
    logic                 accept;
    logic [IDX_W-1:0]     sel_last;
    logic [WORD_BITS-1:0] rd_word;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_word;
    logic [WORD_BITS-1:0] wr_mask;
    logic [OFF_W-1:0]     lo_off, hi_off;
    logic [IDX_W+1:0]     free_end;
    logic [IDX_W-1:0]     free_hi;
    logic [IDX_W-1:0]     alloc_hi;
    logic [ADDR_W-1:0]    addr_inc;

    // Scan unit signals.
    logic [WORD_BITS-1:0] used;
    logic                 lv_h [OFF_W+1][WORD_BITS];
    logic [OFF_W-1:0]     lv_p [OFF_W+1][WORD_BITS];
    logic [WORD_BITS-1:0] hit;
    logic [CNT_W-1:0]     end_len [WORD_BITS];
    logic                 scan_found;
    logic [OFF_W-1:0]     scan_sel;
    logic [IDX_W-1:0]     scan_first;
    logic [CNT_W-1:0]     scan_carry;

    assign accept      = start && !busy;
    assign busy        = (r_step != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign sel_last    = (i_req.region == REGION_RT && r_step == ST_IDLE) ? r_rt_last :
                         (r_req.region == REGION_RT) ? r_rt_last : r_user_last;
    assign rd_word     = r_rd_ok ? r_rd_word : '0;
    assign addr_inc    = ADDR_W'(r_addr + 1'b1);
    assign uw          = ucode(r_step);

    // ------------------------------------------------------------------
    // Scan unit: finds the first position in the current word where a
    // free run reaches the needed length, carrying the run across words.
    // ------------------------------------------------------------------
    always_comb begin
        // Blocks before the search start or past the region end count as used.
        for (int b = 0; b < WORD_BITS; b++) begin
            used[b] = rd_word[b]
                   || (r_first_word && (OFF_W'(b) < r_req.start_index[OFF_W-1:0]))
                   || ({r_addr, OFF_W'(b)} > r_last);
        end

        // Position of the last used bit at or below each lane.
        for (int b = 0; b < WORD_BITS; b++) begin
            lv_h[0][b] = used[b];
            lv_p[0][b] = OFF_W'(b);
        end
        for (int k = 0; k < OFF_W; k++) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                if (!lv_h[k][b] && (b >= (1 << k))) begin
                    lv_h[k+1][b] = lv_h[k][b - (1 << k)];
                    lv_p[k+1][b] = lv_p[k][b - (1 << k)];
                end else begin
                    lv_h[k+1][b] = lv_h[k][b];
                    lv_p[k+1][b] = lv_p[k][b];
                end
            end
        end

        // Free run length ending at each lane.
        for (int b = 0; b < WORD_BITS; b++) begin
            if (lv_h[OFF_W][b]) begin
                end_len[b] = CNT_W'(OFF_W'(OFF_W'(b) - lv_p[OFF_W][b]));
            end else begin
                end_len[b] = CNT_W'(r_len + CNT_W'(b) + CNT_W'(1));
            end
            hit[b] = !used[b] && (end_len[b] >= r_need);
        end

        // Lowest lane where the run is complete.
        scan_found = |hit;
        scan_sel   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (hit[b]) begin
                scan_sel = OFF_W'(b);
            end
        end
        scan_first = IDX_W'(CNT_W'({r_addr, scan_sel}) + CNT_W'(1) - r_need);
        scan_carry = lv_h[OFF_W][WORD_BITS-1] ? end_len[WORD_BITS-1]
                                              : CNT_W'(r_len + CNT_W'(WORD_BITS));
    end

    // ------------------------------------------------------------------
    // Run bounds for marking and freeing.
    // ------------------------------------------------------------------
    always_comb begin
        free_end = (IDX_W+2)'(r_req.start_index) + (IDX_W+2)'(r_req.block_count)
                 - (IDX_W+2)'(1);
        free_hi  = (free_end > (IDX_W+2)'(MAP_BLOCKS - 1)) ? IDX_W'(MAP_BLOCKS - 1)
                                                           : IDX_W'(free_end);
        alloc_hi = IDX_W'(r_first + IDX_W'(r_req.block_count) - IDX_W'(1));
        lo_off   = (r_addr == r_lo[IDX_W-1:OFF_W]) ? r_lo[OFF_W-1:0] : '0;
        hi_off   = (r_addr == r_hi[IDX_W-1:OFF_W]) ? r_hi[OFF_W-1:0] : OFF_W'(WORD_BITS - 1);
        wr_mask  = ({WORD_BITS{1'b1}} << lo_off)
                 & ({WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - hi_off));
        wr_word  = r_set ? (rd_word | wr_mask) : (rd_word & ~wr_mask);
    end

    // ------------------------------------------------------------------
    // Branch condition and step sequencing.
    // ------------------------------------------------------------------
    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_START:   cond_true = !start;
            C_IS_FREE:    cond_true = (r_req.cmd == CMD_FREE);
            C_START_PAST: cond_true = (r_req.start_index > sel_last);
            C_SCAN_AGAIN: cond_true = !scan_found && (r_addr != r_last[IDX_W-1:OFF_W]);
            C_NOT_FOUND:  cond_true = !r_found;
            C_ZERO_COUNT: cond_true = (r_req.block_count == '0);
            C_RMW_AGAIN:  cond_true = (r_addr != r_hi[IDX_W-1:OFF_W]);
            default:      cond_true = 1'b1;
        endcase
        n_step = cond_true ? uw.target : STEP_W'(r_step + 1'b1);
    end

    // ------------------------------------------------------------------
    // Memory port control.
    // ------------------------------------------------------------------
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr;
        wr_en   = 1'b0;
        unique case (uw.act)
            ACT_SCAN_SETUP: begin
                rd_en   = 1'b1;
                rd_addr = r_req.start_index[IDX_W-1:OFF_W];
            end
            ACT_SCAN: begin
                rd_en   = cond_true;
                rd_addr = addr_inc;
            end
            ACT_ALLOC_SETUP: begin
                rd_en   = 1'b1;
                rd_addr = r_first[IDX_W-1:OFF_W];
            end
            ACT_FREE_SETUP: begin
                rd_en   = 1'b1;
                rd_addr = r_req.start_index[IDX_W-1:OFF_W];
            end
            ACT_RMW: begin
                wr_en   = 1'b1;
                rd_en   = cond_true;
                rd_addr = addr_inc;
            end
            default: begin
                rd_en   = 1'b0;
            end
        endcase
    end

    // Map memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr] <= wr_word;
        end
        if (rd_en) begin
            r_rd_word <= mem[rd_addr];
        end
    end

    // Row valid bits: a row never written reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[r_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_ok <= r_row_valid[rd_addr];
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_last <= USER_LAST_RESET;
            r_rt_last   <= RT_LAST_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_USER_LAST) begin
                r_user_last <= i_cfg_data;
            end else if (i_cfg_index == REG_RT_LAST) begin
                r_rt_last <= i_cfg_data;
            end
        end
    end

    // Control state and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_rsp_valid <= (uw.act == ACT_RESULT_OK) || (uw.act == ACT_RESULT_FAIL);
        end
    end

    // Datapath registers driven by the control word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        unique case (uw.act)
            ACT_SCAN_SETUP: begin
                r_last       <= sel_last;
                r_need       <= (r_req.block_count == '0) ? CNT_W'(1) : r_req.block_count;
                r_len        <= '0;
                r_first_word <= 1'b1;
                r_found      <= 1'b0;
                r_addr       <= r_req.start_index[IDX_W-1:OFF_W];
            end
            ACT_SCAN: begin
                r_found      <= scan_found;
                r_first      <= scan_first;
                r_len        <= scan_carry;
                r_first_word <= 1'b0;
                r_addr       <= addr_inc;
            end
            ACT_ALLOC_SETUP: begin
                r_lo   <= r_first;
                r_hi   <= alloc_hi;
                r_set  <= 1'b1;
                r_addr <= r_first[IDX_W-1:OFF_W];
            end
            ACT_FREE_SETUP: begin
                r_lo    <= r_req.start_index;
                r_hi    <= free_hi;
                r_set   <= 1'b0;
                r_first <= '0;
                r_addr  <= r_req.start_index[IDX_W-1:OFF_W];
            end
            ACT_RMW: begin
                r_addr <= addr_inc;
            end
            ACT_RESULT_OK: begin
                r_rsp.success     <= 1'b1;
                r_rsp.first_block <= r_first;
            end
            ACT_RESULT_FAIL: begin
                r_rsp.success     <= 1'b0;
                r_rsp.first_block <= '0;
            end
            default: begin
                r_addr <= r_addr;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_rsp_from_result_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> ($past(r_step) == ST_OK || $past(r_step) == ST_FAIL))
        else $error("result strobe without a result step");

    a_busy_needs_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted request");

    a_scan_in_region : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_ASCAN) |-> (r_addr <= r_last[IDX_W-1:OFF_W]))
        else $error("scan passed the region end");

    a_fail_zero_block : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.success) |-> (o_rsp.first_block == '0))
        else $error("failed allocation returned a block");

endmodule
